// ----- rtl/ddoi_pkg.sv -----
`timescale 1ns / 1ps
package ddoi_pkg;

  localparam int unsigned DataW = 32;
  localparam int unsigned PosW  = 48;

  localparam logic signed [33:0] TwoPiQ28  = 34'sd1686629713;
  localparam logic signed [33:0] PiQ28     = 34'sd843314857;
  localparam logic signed [33:0] HalfPiQ28 = 34'sd421657428;
  localparam logic [31:0]        Deg2RadQ32 = 32'd74961321;
  localparam logic signed [33:0] GainQ30   = 34'sd652032874;
  localparam logic signed [33:0] OneQ30    = 34'sd1073741824;
  localparam logic [31:0]        DtReset   = 32'd4294967;

  typedef enum logic [0:0] {
    OpIntegrate = 1'b0,
    OpClear     = 1'b1
  } op_e;

  // Arctangent of 2^-i in Q4.28.
  function automatic logic [27:0] atan_q28(input logic [4:0] idx);
    logic [27:0] r;
    unique case (idx)
      5'd0:  r = 28'd210828714;
      5'd1:  r = 28'd124459457;
      5'd2:  r = 28'd65760959;
      5'd3:  r = 28'd33381290;
      5'd4:  r = 28'd16755422;
      5'd5:  r = 28'd8385879;
      5'd6:  r = 28'd4193963;
      5'd7:  r = 28'd2097109;
      5'd8:  r = 28'd1048571;
      5'd9:  r = 28'd524287;
      5'd10: r = 28'd262144;
      5'd11: r = 28'd131072;
      5'd12: r = 28'd65536;
      5'd13: r = 28'd32768;
      5'd14: r = 28'd16384;
      5'd15: r = 28'd8192;
      5'd16: r = 28'd4096;
      5'd17: r = 28'd2048;
      5'd18: r = 28'd1024;
      5'd19: r = 28'd512;
      5'd20: r = 28'd256;
      5'd21: r = 28'd128;
      5'd22: r = 28'd64;
      5'd23: r = 28'd32;
      5'd24: r = 28'd16;
      5'd25: r = 28'd8;
      5'd26: r = 28'd4;
      5'd27: r = 28'd2;
      5'd28: r = 28'd1;
      default: r = 28'd0;
    endcase
    return r;
  endfunction

endpackage

// ----- rtl/ddoi_serial_mul.sv -----
`timescale 1ns / 1ps
// Shift-and-add signed multiplier: signed A times B (signed or unsigned),
// one multiplier bit per cycle.
module ddoi_serial_mul #(
  parameter int unsigned AW = 48,
  parameter int unsigned BW = 34
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    start_i,
  input  logic                    b_signed_i,
  input  logic signed [AW-1:0]    a_i,
  input  logic [BW-1:0]           b_i,
  output logic                    done_o,
  output logic signed [AW+BW-1:0] prod_o
);

  localparam int unsigned CntW = $clog2(BW + 1);
  localparam int unsigned PW   = AW + BW;

  logic [CntW-1:0]       cnt_q, cnt_d;
  logic                  busy_q, busy_d;
  logic                  bsgn_q, bsgn_d;
  logic signed [PW-1:0]  a_q, a_d;
  logic [BW-1:0]         b_q, b_d;
  logic signed [PW-1:0]  acc_q, acc_d;
  logic                  done_q, done_d;
  logic signed [PW-1:0]  term;

  // Weight of the top bit is negative for signed operands.
  always_comb begin
    term = b_q[0] ? a_q : '0;
    if (bsgn_q && (cnt_q == CntW'(BW - 1))) begin
      term = -term;
    end
  end

  always_comb begin
    cnt_d  = cnt_q;
    busy_d = busy_q;
    bsgn_d = bsgn_q;
    a_d    = a_q;
    b_d    = b_q;
    acc_d  = acc_q;
    done_d = 1'b0;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      bsgn_d = b_signed_i;
      a_d    = PW'(a_i);
      b_d    = b_i;
      acc_d  = '0;
    end else if (busy_q) begin
      acc_d = acc_q + term;
      a_d   = a_q <<< 1;
      b_d   = b_q >> 1;
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(BW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bsgn_q <= bsgn_d;
    a_q    <= a_d;
    b_q    <= b_d;
    acc_q  <= acc_d;
  end

  assign done_o = done_q;
  assign prod_o = acc_q;

endmodule

// ----- rtl/diff_drive_odometry_integrator_top.sv -----
`timescale 1ns / 1ps
// An integrate word runs six bit-serial products plus the CORDIC loop before its result is shown.
// A clear word passes through StOut before its result is shown.
// Throughput: one word at a time; the next word is taken in the cycle after the result leaves.
// Reset: pose, twist and control clear; time_step returns to about 1 ms.
module diff_drive_odometry_integrator_top #(
  parameter int unsigned CORDIC_STAGES = 24
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               operation_i,
  input  logic signed [31:0] left_speed_i,
  input  logic signed [31:0] right_speed_i,
  input  logic signed [31:0] yaw_rate_deg_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [47:0] position_x_o,
  output logic signed [47:0] position_y_o,
  output logic signed [31:0] heading_o,
  output logic signed [31:0] linear_speed_o,
  output logic signed [31:0] angular_speed_o
);

  localparam int unsigned ItW = $clog2(CORDIC_STAGES + 1);
  localparam int unsigned AW  = 48;
  localparam int unsigned BW  = 34;

  typedef enum logic [11:0] {
    StIdle  = 12'b000000000001,
    StW     = 12'b000000000010,
    StStep  = 12'b000000000100,
    StHead  = 12'b000000001000,
    StCord  = 12'b000000010000,
    StXc    = 12'b000000100000,
    StXdt   = 12'b000001000000,
    StYs    = 12'b000010000000,
    StYdt   = 12'b000100000000,
    StWait  = 12'b001000000000,
    StOut   = 12'b010000000000,
    StLaunch = 12'b100000000000
  } state_e;

  state_e state_q, state_d;
  state_e next_q, next_d;

  logic [31:0]        dt_q;
  logic signed [47:0] px_q, px_d, py_q, py_d;
  logic signed [31:0] th_q, th_d, v_q, v_d, w_q, w_d;
  logic signed [33:0] z_q, z_d, cx_q, cx_d, cy_q, cy_d;
  logic               neg_q, neg_d;
  logic [ItW-1:0]     it_q, it_d;
  logic               out_valid_q, out_valid_d;

  // Multiplier operand control.
  logic               m_start;
  logic               m_bsgn;
  logic signed [AW-1:0] m_a;
  logic [BW-1:0]      m_b;
  logic               m_done;
  logic signed [AW+BW-1:0] m_p;

  logic signed [AW-1:0] m_a_q, m_a_d;
  logic [BW-1:0]      m_b_q, m_b_d;
  logic               m_bs_q, m_bs_d;

  ddoi_serial_mul #(.AW(AW), .BW(BW)) u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (m_start),
    .b_signed_i(m_bsgn),
    .a_i       (m_a),
    .b_i       (m_b),
    .done_o    (m_done),
    .prod_o    (m_p)
  );

  assign m_a   = m_a_q;
  assign m_b   = m_b_q;
  assign m_bsgn = m_bs_q;
  assign m_start = (state_q == StLaunch);

  // Rounding shifts on the product.
  logic signed [AW+BW-1:0] p_r20, p_r30, p_r32;
  assign p_r20 = (m_p >>> 20) + $signed((AW+BW)'(m_p[19]));
  assign p_r30 = (m_p >>> 30) + $signed((AW+BW)'(m_p[29]));
  assign p_r32 = (m_p >>> 32) + $signed((AW+BW)'(m_p[31]));

  // CORDIC iteration datapath.
  logic signed [33:0] cx_sh, cy_sh, atan_v;
  assign cx_sh  = cx_q >>> it_q;
  assign cy_sh  = cy_q >>> it_q;
  assign atan_v = 34'(ddoi_pkg::atan_q28(5'(it_q)));

  // Heading fold and range reduction helpers.
  logic signed [33:0] th_sum, th_base, th_new, zr;
  logic signed [49:0] pos_sum;

  always_comb begin
    state_d = state_q;
    next_d  = next_q;
    px_d = px_q; py_d = py_q; th_d = th_q; v_d = v_q; w_d = w_q;
    z_d = z_q; cx_d = cx_q; cy_d = cy_q; neg_d = neg_q; it_d = it_q;
    m_a_d = m_a_q; m_b_d = m_b_q; m_bs_d = m_bs_q;
    out_valid_d = out_valid_q;
    th_sum = '0; th_base = '0; th_new = '0; zr = '0; pos_sum = '0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StIdle: begin
        if (in_valid_i && !out_valid_q) begin
          if (ddoi_pkg::op_e'(operation_i) == ddoi_pkg::OpClear) begin
            px_d = '0; py_d = '0; th_d = '0; v_d = '0; w_d = '0;
            state_d = StOut;
          end else begin
            v_d   = 32'((33'(left_speed_i) + 33'(right_speed_i)) >>> 1);
            m_a_d = AW'(yaw_rate_deg_i);
            m_b_d = {2'b00, ddoi_pkg::Deg2RadQ32};
            m_bs_d = 1'b0;
            next_d  = StW;
            state_d = StLaunch;
          end
        end
      end
      StLaunch: begin
        state_d = StWait;
      end
      StWait: begin
        if (m_done) begin
          state_d = next_q;
        end
      end
      StW: begin
        // Saturate to Q4.28 and start w*dt.
        if (p_r20 > 82'sd2147483647) begin
          w_d = 32'sh7fffffff;
        end else if (p_r20 < -82'sd2147483648) begin
          w_d = 32'sh80000000;
        end else begin
          w_d = 32'(p_r20);
        end
        m_a_d = AW'(w_d);
        m_b_d = {2'b00, dt_q};
        m_bs_d = 1'b0;
        next_d  = StStep;
        state_d = StLaunch;
      end
      StStep: begin
        th_sum = 34'(th_q) + 34'(p_r32);
        if (th_sum > ddoi_pkg::TwoPiQ28) begin
          th_base = 34'(th_q) - ddoi_pkg::TwoPiQ28;
        end else if (th_sum < -ddoi_pkg::TwoPiQ28) begin
          th_base = 34'(th_q) + ddoi_pkg::TwoPiQ28;
        end else begin
          th_base = 34'(th_q);
        end
        th_new = th_base + 34'(p_r32);
        if (th_new > 34'sd2147483647) begin
          th_d = 32'sh7fffffff;
        end else if (th_new < -34'sd2147483648) begin
          th_d = 32'sh80000000;
        end else begin
          th_d = 32'(th_new);
        end
        state_d = StHead;
      end
      StHead: begin
        // Bring angle into [-pi/2, pi/2].
        zr = 34'(th_q);
        if (zr > ddoi_pkg::PiQ28) begin
          zr = zr - ddoi_pkg::TwoPiQ28;
        end
        if (zr > ddoi_pkg::PiQ28) begin
          zr = zr - ddoi_pkg::TwoPiQ28;
        end
        if (zr < -ddoi_pkg::PiQ28) begin
          zr = zr + ddoi_pkg::TwoPiQ28;
        end
        if (zr < -ddoi_pkg::PiQ28) begin
          zr = zr + ddoi_pkg::TwoPiQ28;
        end
        neg_d = 1'b0;
        if (zr > ddoi_pkg::HalfPiQ28) begin
          zr = zr - ddoi_pkg::PiQ28;
          neg_d = 1'b1;
        end else if (zr < -ddoi_pkg::HalfPiQ28) begin
          zr = zr + ddoi_pkg::PiQ28;
          neg_d = 1'b1;
        end
        z_d  = zr;
        cx_d = ddoi_pkg::GainQ30;
        cy_d = '0;
        it_d = '0;
        state_d = StCord;
      end
      StCord: begin
        if (it_q == ItW'(CORDIC_STAGES)) begin
          if (neg_q) begin
            cx_d = -cx_q;
            cy_d = -cy_q;
          end
          if (cx_d > ddoi_pkg::OneQ30) cx_d = ddoi_pkg::OneQ30;
          if (cx_d < -ddoi_pkg::OneQ30) cx_d = -ddoi_pkg::OneQ30;
          if (cy_d > ddoi_pkg::OneQ30) cy_d = ddoi_pkg::OneQ30;
          if (cy_d < -ddoi_pkg::OneQ30) cy_d = -ddoi_pkg::OneQ30;
          m_a_d = AW'(v_q);
          m_b_d = (neg_q ? -cx_q : cx_q) > ddoi_pkg::OneQ30 ? ddoi_pkg::OneQ30 :
                  (neg_q ? -cx_q : cx_q) < -ddoi_pkg::OneQ30 ? -ddoi_pkg::OneQ30 :
                  (neg_q ? -cx_q : cx_q);
          m_bs_d = 1'b1;
          next_d  = StXc;
          state_d = StLaunch;
        end else begin
          if (!z_q[33]) begin
            cx_d = cx_q - cy_sh;
            cy_d = cy_q + cx_sh;
            z_d  = z_q - atan_v;
          end else begin
            cx_d = cx_q + cy_sh;
            cy_d = cy_q - cx_sh;
            z_d  = z_q + atan_v;
          end
          it_d = it_q + 1'b1;
        end
      end
      StXc: begin
        m_a_d = AW'(p_r30);
        m_b_d = {2'b00, dt_q};
        m_bs_d = 1'b0;
        next_d  = StXdt;
        state_d = StLaunch;
      end
      StXdt: begin
        pos_sum = 50'(px_q) + 50'(p_r32);
        if (pos_sum > 50'sd140737488355327) begin
          px_d = 48'sh7fffffffffff;
        end else if (pos_sum < -50'sd140737488355328) begin
          px_d = 48'sh800000000000;
        end else begin
          px_d = 48'(pos_sum);
        end
        m_a_d = AW'(v_q);
        m_b_d = cy_q;
        m_bs_d = 1'b1;
        next_d  = StYs;
        state_d = StLaunch;
      end
      StYs: begin
        m_a_d = AW'(p_r30);
        m_b_d = {2'b00, dt_q};
        m_bs_d = 1'b0;
        next_d  = StYdt;
        state_d = StLaunch;
      end
      StYdt: begin
        pos_sum = 50'(py_q) + 50'(p_r32);
        if (pos_sum > 50'sd140737488355327) begin
          py_d = 48'sh7fffffffffff;
        end else if (pos_sum < -50'sd140737488355328) begin
          py_d = 48'sh800000000000;
        end else begin
          py_d = 48'(pos_sum);
        end
        state_d = StOut;
      end
      StOut: begin
        out_valid_d = 1'b1;
        state_d = StIdle;
      end
      default: state_d = StIdle;
    endcase
  end

  // Hold control, pose, twist and time step state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      next_q  <= StIdle;
      out_valid_q <= 1'b0;
      dt_q <= ddoi_pkg::DtReset;
      px_q <= '0; py_q <= '0; th_q <= '0; v_q <= '0; w_q <= '0;
    end else begin
      state_q <= state_d;
      next_q  <= next_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        dt_q <= cfg_wdata_i;
      end
      px_q <= px_d; py_q <= py_d; th_q <= th_d; v_q <= v_d; w_q <= w_d;
    end
  end

  always_ff @(posedge clk_i) begin
    z_q <= z_d; cx_q <= cx_d; cy_q <= cy_d; neg_q <= neg_d; it_q <= it_d;
    m_a_q <= m_a_d; m_b_q <= m_b_d; m_bs_q <= m_bs_d;
  end

  assign in_stall_o      = (state_q != StIdle) || out_valid_q;
  assign out_valid_o     = out_valid_q;
  assign position_x_o    = px_q;
  assign position_y_o    = py_q;
  assign heading_o       = th_q;
  assign linear_speed_o  = v_q;
  assign angular_speed_o = w_q;

endmodule
